FILE: src/elevator_group_dispatcher_unit_defines.svh
// Assertion macros used by the dispatcher controller
`ifndef ELEVATOR_GROUP_DISPATCHER_UNIT_DEFINES_SVH
`define ELEVATOR_GROUP_DISPATCHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EGD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define EGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/egd_pkg.sv
// Types, constants and control/status structs of the elevator group dispatcher
`timescale 1ns / 1ps
package egd_pkg;

	localparam int FLOORS      = 16;
	localparam int CARS        = 2;
	localparam int FIRST_FLOOR = 1;

	localparam int FIDX_W    = $clog2(FLOORS);
	localparam int CAR_W     = $clog2(CARS);
	localparam int FLOOR_W   = 5;
	localparam int CNT_W     = $clog2(3 * FLOORS + 1);
	localparam int WGT_W     = 18;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [FIDX_W-1:0] HOME_FLOOR = (FIRST_FLOOR > FLOORS) ?
		FIDX_W'(FLOORS - 1) : FIDX_W'(FIRST_FLOOR - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_WEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_WEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BONUS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALONG_BONUS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AWAY_PENALTY    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_PENALTY    = 3'd5;

	localparam logic [CFG_W-1:0] RST_DISTANCE_WEIGHT = 8'd10;
	localparam logic [CFG_W-1:0] RST_LOAD_WEIGHT     = 8'd20;
	localparam logic [CFG_W-1:0] RST_IDLE_BONUS      = 8'd15;
	localparam logic [CFG_W-1:0] RST_ALONG_BONUS     = 8'd25;
	localparam logic [CFG_W-1:0] RST_AWAY_PENALTY    = 8'd30;
	localparam logic [CFG_W-1:0] RST_TURN_PENALTY    = 8'd15;

	typedef enum logic [1:0] {OP_HALL, OP_CABIN, OP_TICK, OP_BOARD} op_t;
	typedef enum logic [2:0] {
		KIND_FREE, KIND_MOVE, KIND_STOP, KIND_POSITION, KIND_LAMP_ON, KIND_LAMP_OFF
	} kind_t;
	typedef enum logic [1:0] {MV_STAND, MV_UP, MV_DOWN} motion_t;
	typedef enum logic [1:0] {LAMP_HALL_UP, LAMP_HALL_DOWN, LAMP_CABIN} lamp_t;
	typedef enum logic [2:0] {PH_FREE = 3'd0, PH_MANAGE_CABIN = 3'd3} phase_t;
	typedef enum logic [2:0] {RES_STOP, RES_POS, RES_CMD, RES_LAMP_ON, RES_LAMP_OFF} res_sel_t;

	typedef struct packed {
		logic     emit;
		res_sel_t res_sel;
		logic     last;
		lamp_t    group;
		logic     sweep_step;
		logic     car_first;
		logic     car_next;
		logic     car_best;
		logic     weigh;
		logic     set_hall;
		logic     set_cabin;
		logic     tick_move;
		logic     clear_lamp;
		logic     stand;
		logic     manage;
	} egd_cmd_t;

	typedef struct packed {
		op_t  op;
		logic floor_ok;
		logic car_ok;
		logic call_ok;
		logic tick_ok;
		logic dup_hall;
		logic dup_cabin;
		logic stand_hit;
		logic sweep_last;
		logic car_last;
		logic hit_cabin;
		logic hit_up;
		logic hit_down;
	} egd_stat_t;

endpackage

FILE: src/egd_datapath.sv
// Dispatcher datapath: car state, call maps, floor sweep, weights and results
`timescale 1ns / 1ps
module egd_datapath import egd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [1:0]           operation,
	input  logic [FLOOR_W-1:0]   floor,
	input  logic                 call_direction,
	input  logic                 car,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  egd_cmd_t             cmd,
	output egd_stat_t            st,
	output logic                 result_strobe,
	output logic [2:0]           kind,
	output logic                 car_index,
	output logic [FLOOR_W-1:0]   floor_number,
	output logic [1:0]           heading,
	output logic [1:0]           lamp_group,
	output logic                 last
);

	// captured item
	op_t                     op_q;
	logic [FLOOR_W-1:0]      floor_q;
	logic                    dir_q;
	logic [CAR_W-1:0]        car_q;
	logic [CAR_W-1:0]        best_q;
	logic signed [WGT_W-1:0] bw_q;

	logic [CFG_W-1:0] dw_q, lw_q, ib_q, alb_q, ap_q, tp_q;

	// car state and call maps
	phase_t             phase_q;
	logic [FIDX_W-1:0]  pos_q  [CARS];
	motion_t            mot_q  [CARS];
	logic               pref_q [CARS];
	logic [FLOORS-1:0]  cab_q  [CARS];
	logic [FLOORS-1:0]  hu_q   [CARS];
	logic [FLOORS-1:0]  hd_q   [CARS];

	// sweep records
	logic [FIDX_W-1:0] sf_q;
	logic              upf_v_q, upr_v_q, dnr_v_q, dnf_v_q, ab_v_q, bl_v_q;
	logic [FIDX_W-1:0] upf_i_q, upr_i_q, dnr_i_q, dnf_i_q, ab_i_q, bl_i_q;
	logic [CNT_W-1:0]  cnt_q;

	// result registers
	logic               strobe_q, last_q;
	kind_t              kind_q;
	logic [CAR_W-1:0]   rcar_q;
	logic [FLOOR_W-1:0] rfloor_q;
	motion_t            rdir_q;
	lamp_t              rgrp_q;

	logic [FLOOR_W-1:0] fm1, cur_num;
	logic [FIDX_W-1:0]  fidx, cur, span;
	motion_t            mot, need, want;
	logic               pref;
	logic [FLOORS-1:0]  cm, um, dm, am;
	logic [FIDX_W+CFG_W-1:0] dprod;
	logic [CNT_W+CFG_W-1:0]  lprod;
	logic signed [WGT_W-1:0] w;
	logic               any_all, stand_hit, dup_hall;
	logic [CAR_W-1:0]   stand_idx;

	assign fm1     = floor_q - 1'b1;
	assign fidx    = fm1[FIDX_W-1:0];
	assign cur     = pos_q[car_q];
	assign cur_num = FLOOR_W'(cur) + 1'b1;
	assign mot     = mot_q[car_q];
	assign pref    = pref_q[car_q];
	assign cm      = cab_q[car_q];
	assign um      = hu_q[car_q];
	assign dm      = hd_q[car_q];
	assign am      = cm | um | dm;

	// checks over all cars
	always_comb begin
		any_all   = 1'b0;
		stand_hit = 1'b0;
		stand_idx = '0;
		dup_hall  = 1'b0;
		for (int k = CARS - 1; k >= 0; k--) begin
			if ((cab_q[k] | hu_q[k] | hd_q[k]) != '0)
				any_all = 1'b1;
			if (dir_q ? hd_q[k][fidx] : hu_q[k][fidx])
				dup_hall = 1'b1;
			if (pos_q[k] == fidx && mot_q[k] == MV_STAND) begin
				stand_hit = 1'b1;
				stand_idx = CAR_W'(k);
			end
		end
	end

	assign st.op         = op_q;
	assign st.floor_ok   = (floor_q != '0) && (floor_q <= FLOOR_W'(FLOORS));
	assign st.car_ok     = (32'(car_q) < CARS);
	assign st.call_ok    = (phase_q == PH_FREE) || (phase_q == PH_MANAGE_CABIN);
	assign st.tick_ok    = (phase_q == PH_MANAGE_CABIN);
	assign st.dup_hall   = dup_hall;
	assign st.dup_cabin  = cm[fidx];
	assign st.stand_hit  = stand_hit;
	assign st.sweep_last = (sf_q == FIDX_W'(FLOORS - 1));
	assign st.car_last   = (car_q == CAR_W'(CARS - 1));
	assign st.hit_cabin  = cm[cur];
	assign st.hit_up     = um[cur];
	assign st.hit_down   = dm[cur];

	// weight of car_q for the captured hall call
	assign span  = (fidx > cur) ? fidx - cur : cur - fidx;
	assign dprod = span * dw_q;
	assign lprod = cnt_q * lw_q;
	assign need  = (fidx > cur) ? MV_UP : ((fidx < cur) ? MV_DOWN : MV_STAND);
	assign want  = dir_q ? MV_DOWN : MV_UP;

	always_comb begin
		w = $signed(WGT_W'(dprod)) + $signed(WGT_W'(lprod));
		if (mot == MV_STAND) begin
			w = w - $signed(WGT_W'(ib_q));
		end else begin
			if (mot == need && mot == want)
				w = w - $signed(WGT_W'(alb_q));
			else if (mot != need)
				w = w + $signed(WGT_W'(ap_q));
			if (mot != need && need != MV_STAND)
				w = w + $signed(WGT_W'(tp_q));
		end
	end

	// sweep step: one floor per cycle, records restart at floor index zero
	logic fresh, above, below, cb, ub, db;
	logic              n_upf_v, n_upr_v, n_dnr_v, n_dnf_v, n_ab_v, n_bl_v;
	logic [FIDX_W-1:0] n_upf_i, n_upr_i, n_dnr_i, n_dnf_i, n_ab_i, n_bl_i;
	logic [CNT_W-1:0]  n_cnt;

	always_comb begin
		fresh = (sf_q == '0);
		above = sf_q > cur;
		below = sf_q < cur;
		cb = cm[sf_q];
		ub = um[sf_q];
		db = dm[sf_q];
		n_upf_v = fresh ? 1'b0 : upf_v_q;  n_upf_i = upf_i_q;
		n_upr_v = fresh ? 1'b0 : upr_v_q;  n_upr_i = upr_i_q;
		n_dnr_v = fresh ? 1'b0 : dnr_v_q;  n_dnr_i = dnr_i_q;
		n_dnf_v = fresh ? 1'b0 : dnf_v_q;  n_dnf_i = dnf_i_q;
		n_ab_v  = fresh ? 1'b0 : ab_v_q;   n_ab_i  = ab_i_q;
		n_bl_v  = fresh ? 1'b0 : bl_v_q;   n_bl_i  = bl_i_q;
		n_cnt   = (fresh ? '0 : cnt_q) + CNT_W'(cb) + CNT_W'(ub) + CNT_W'(db);
		// nearest cabin or hall-up call above
		if (!n_upf_v && above && (cb || ub)) begin
			n_upf_v = 1'b1;  n_upf_i = sf_q;
		end
		// highest hall-down above: turnaround point going up
		if (above && db) begin
			n_upr_v = 1'b1;  n_upr_i = sf_q;
		end
		// lowest hall-up below: turnaround point going down
		if (!n_dnr_v && below && ub) begin
			n_dnr_v = 1'b1;  n_dnr_i = sf_q;
		end
		// nearest cabin or hall-down call below
		if (below && (cb || db)) begin
			n_dnf_v = 1'b1;  n_dnf_i = sf_q;
		end
		if (!n_ab_v && above && (cb || ub || db)) begin
			n_ab_v = 1'b1;  n_ab_i = sf_q;
		end
		if (below && (cb || ub || db)) begin
			n_bl_v = 1'b1;  n_bl_i = sf_q;
		end
	end

	// next floor choice and new motion, from a finished sweep
	logic              su_v, sd_v, t_v, flip;
	logic [FIDX_W-1:0] su_i, sd_i, t_i, du, dd;
	motion_t           mg_dir;
	kind_t             mg_kind;

	always_comb begin
		su_v = 1'b1;  su_i = upf_i_q;
		if (!(upf_v_q && (!upr_v_q || upf_i_q < upr_i_q))) begin
			su_v = upr_v_q;  su_i = upr_i_q;
		end
		sd_v = 1'b1;  sd_i = dnf_i_q;
		if (!(dnf_v_q && (!dnr_v_q || dnf_i_q > dnr_i_q))) begin
			sd_v = dnr_v_q;  sd_i = dnr_i_q;
		end
		t_v  = 1'b0;
		t_i  = cur;
		flip = 1'b0;
		if (cnt_q == '0) begin
			t_v = 1'b0;
		end else if (am[cur]) begin
			t_v = 1'b1;
		end else if (mot != MV_STAND) begin
			t_v = (mot == MV_UP) ? su_v : sd_v;
			t_i = (mot == MV_UP) ? su_i : sd_i;
		end else if (pref ? ab_v_q : bl_v_q) begin
			t_v = pref ? su_v : sd_v;
			t_i = pref ? su_i : sd_i;
		end else if (pref ? bl_v_q : ab_v_q) begin
			// nothing ahead in the preferred direction: turn round
			flip = 1'b1;
			t_v  = 1'b1;
			t_i  = pref ? bl_i_q : ab_i_q;
		end
		du = ab_i_q - cur;
		dd = cur - bl_i_q;
		if (!t_v) begin
			mg_kind = KIND_FREE;  mg_dir = MV_STAND;
		end else if (t_i > cur) begin
			mg_kind = KIND_MOVE;  mg_dir = MV_UP;
		end else if (t_i < cur) begin
			mg_kind = KIND_MOVE;  mg_dir = MV_DOWN;
		end else begin
			mg_kind = KIND_STOP;
			if (mot != MV_STAND)
				mg_dir = MV_STAND;
			else if (ab_v_q && bl_v_q && du == dd)
				mg_dir = pref ? MV_UP : MV_DOWN;
			else if (ab_v_q && (!bl_v_q || du < dd))
				mg_dir = MV_UP;
			else if (bl_v_q)
				mg_dir = MV_DOWN;
			else
				mg_dir = MV_STAND;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q  <= RST_DISTANCE_WEIGHT;
			lw_q  <= RST_LOAD_WEIGHT;
			ib_q  <= RST_IDLE_BONUS;
			alb_q <= RST_ALONG_BONUS;
			ap_q  <= RST_AWAY_PENALTY;
			tp_q  <= RST_TURN_PENALTY;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DISTANCE_WEIGHT: dw_q  <= cfg_data;
				CFG_LOAD_WEIGHT:     lw_q  <= cfg_data;
				CFG_IDLE_BONUS:      ib_q  <= cfg_data;
				CFG_ALONG_BONUS:     alb_q <= cfg_data;
				CFG_AWAY_PENALTY:    ap_q  <= cfg_data;
				CFG_TURN_PENALTY:    tp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture, car pointer and best-weight tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_q <= '0;
		end else if (take) begin
			car_q <= CAR_W'(car);
		end else if (cmd.car_first) begin
			car_q <= '0;
		end else if (cmd.car_next) begin
			car_q <= car_q + 1'b1;
		end else if (cmd.car_best) begin
			car_q <= best_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= op_t'(operation);
			floor_q <= floor;
			dir_q   <= call_direction;
		end
		if (cmd.weigh && (car_q == '0 || w < bw_q)) begin
			bw_q   <= w;
			best_q <= car_q;
		end
	end

	// sweep registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= '0;
		end else if (cmd.sweep_step) begin
			sf_q <= (sf_q == FIDX_W'(FLOORS - 1)) ? '0 : sf_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			upf_v_q <= n_upf_v;  upf_i_q <= n_upf_i;
			upr_v_q <= n_upr_v;  upr_i_q <= n_upr_i;
			dnr_v_q <= n_dnr_v;  dnr_i_q <= n_dnr_i;
			dnf_v_q <= n_dnf_v;  dnf_i_q <= n_dnf_i;
			ab_v_q  <= n_ab_v;   ab_i_q  <= n_ab_i;
			bl_v_q  <= n_bl_v;   bl_i_q  <= n_bl_i;
			cnt_q   <= n_cnt;
		end
	end

	// car state and call maps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FREE;
			for (int k = 0; k < CARS; k++) begin
				pos_q[k]  <= HOME_FLOOR;
				mot_q[k]  <= MV_STAND;
				pref_q[k] <= 1'b1;
				cab_q[k]  <= '0;
				hu_q[k]   <= '0;
				hd_q[k]   <= '0;
			end
		end else begin
			if (cmd.set_hall) begin
				if (dir_q)
					hd_q[best_q][fidx] <= 1'b1;
				else
					hu_q[best_q][fidx] <= 1'b1;
			end
			if (cmd.set_cabin)
				cab_q[car_q][fidx] <= 1'b1;
			if (cmd.tick_move) begin
				if (mot == MV_UP && cur < FIDX_W'(FLOORS - 1))
					pos_q[car_q] <= cur + 1'b1;
				else if (mot == MV_DOWN && cur > '0)
					pos_q[car_q] <= cur - 1'b1;
			end
			if (cmd.clear_lamp) begin
				case (cmd.group)
					LAMP_CABIN:     cab_q[car_q][cur] <= 1'b0;
					LAMP_HALL_UP:   hu_q[car_q][cur]  <= 1'b0;
					LAMP_HALL_DOWN: hd_q[car_q][cur]  <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.stand)
				mot_q[car_q] <= MV_STAND;
			if (cmd.manage) begin
				mot_q[car_q] <= mg_dir;
				if (flip)
					pref_q[car_q] <= ~pref;
				phase_q <= any_all ? PH_MANAGE_CABIN : PH_FREE;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= cmd.last;
			case (cmd.res_sel)
				RES_STOP: begin
					kind_q   <= KIND_STOP;
					rcar_q   <= stand_idx;
					rfloor_q <= floor_q;
					rdir_q   <= MV_STAND;
					rgrp_q   <= LAMP_HALL_UP;
				end
				RES_POS: begin
					kind_q   <= KIND_POSITION;
					rcar_q   <= car_q;
					rfloor_q <= cur_num;
					rdir_q   <= mot;
					rgrp_q   <= LAMP_HALL_UP;
				end
				RES_CMD: begin
					kind_q   <= mg_kind;
					rcar_q   <= car_q;
					rfloor_q <= cur_num;
					rdir_q   <= mg_dir;
					rgrp_q   <= LAMP_HALL_UP;
				end
				RES_LAMP_ON: begin
					kind_q   <= KIND_LAMP_ON;
					rcar_q   <= car_q;
					rfloor_q <= floor_q;
					rdir_q   <= MV_STAND;
					rgrp_q   <= (op_q == OP_CABIN) ? LAMP_CABIN :
						(dir_q ? LAMP_HALL_DOWN : LAMP_HALL_UP);
				end
				default: begin
					kind_q   <= KIND_LAMP_OFF;
					rcar_q   <= car_q;
					rfloor_q <= cur_num;
					rdir_q   <= MV_STAND;
					rgrp_q   <= cmd.group;
				end
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign car_index     = rcar_q[0];
	assign floor_number  = rfloor_q;
	assign heading       = rdir_q;
	assign lamp_group    = rgrp_q;
	assign last          = last_q;

endmodule

FILE: src/egd_ctrl.sv
// Dispatcher controller: sequences checks, floor sweeps, commands and lamps
`timescale 1ns / 1ps
`include "elevator_group_dispatcher_unit_defines.svh"
module egd_ctrl import egd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  egd_stat_t st,
	output egd_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_POS, ST_W_SWEEP, ST_W_EVAL, ST_SET_HALL,
		ST_M_SWEEP, ST_M_CMD, ST_LAMP_ON, ST_OFF_C, ST_OFF_U, ST_OFF_D
	} state_t;

	state_t state_q, nxt;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start)
					nxt = ST_CHECK;
			end
			ST_CHECK: begin
				case (st.op)
					OP_HALL: begin
						if (!st.floor_ok || !st.call_ok || st.dup_hall) begin
							nxt = ST_IDLE;
						end else if (st.stand_hit) begin
							cmd.emit    = 1'b1;
							cmd.res_sel = RES_STOP;
							cmd.last    = 1'b1;
							nxt         = ST_IDLE;
						end else begin
							cmd.car_first = 1'b1;
							nxt           = ST_W_SWEEP;
						end
					end
					OP_CABIN: begin
						if (!st.floor_ok || !st.car_ok || !st.call_ok || st.dup_cabin) begin
							nxt = ST_IDLE;
						end else begin
							cmd.set_cabin = 1'b1;
							nxt           = ST_M_SWEEP;
						end
					end
					OP_TICK: begin
						if (!st.car_ok || !st.tick_ok) begin
							nxt = ST_IDLE;
						end else begin
							cmd.tick_move = 1'b1;
							nxt           = ST_POS;
						end
					end
					default: begin
						nxt = (!st.car_ok || !st.tick_ok) ? ST_IDLE : ST_OFF_C;
					end
				endcase
			end
			ST_POS: begin
				cmd.emit    = 1'b1;
				cmd.res_sel = RES_POS;
				nxt         = ST_M_SWEEP;
			end
			ST_W_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_last)
					nxt = ST_W_EVAL;
			end
			ST_W_EVAL: begin
				cmd.weigh = 1'b1;
				if (st.car_last) begin
					nxt = ST_SET_HALL;
				end else begin
					cmd.car_next = 1'b1;
					nxt          = ST_W_SWEEP;
				end
			end
			ST_SET_HALL: begin
				cmd.set_hall = 1'b1;
				cmd.car_best = 1'b1;
				nxt          = ST_M_SWEEP;
			end
			ST_M_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_last)
					nxt = ST_M_CMD;
			end
			ST_M_CMD: begin
				cmd.manage  = 1'b1;
				cmd.emit    = 1'b1;
				cmd.res_sel = RES_CMD;
				cmd.last    = (st.op == OP_TICK) || (st.op == OP_BOARD);
				nxt         = cmd.last ? ST_IDLE : ST_LAMP_ON;
			end
			ST_LAMP_ON: begin
				cmd.emit    = 1'b1;
				cmd.res_sel = RES_LAMP_ON;
				cmd.last    = 1'b1;
				nxt         = ST_IDLE;
			end
			ST_OFF_C: begin
				cmd.group      = LAMP_CABIN;
				cmd.res_sel    = RES_LAMP_OFF;
				cmd.emit       = st.hit_cabin;
				cmd.clear_lamp = st.hit_cabin;
				nxt            = ST_OFF_U;
			end
			ST_OFF_U: begin
				cmd.group      = LAMP_HALL_UP;
				cmd.res_sel    = RES_LAMP_OFF;
				cmd.emit       = st.hit_up;
				cmd.clear_lamp = st.hit_up;
				nxt            = ST_OFF_D;
			end
			ST_OFF_D: begin
				cmd.group      = LAMP_HALL_DOWN;
				cmd.res_sel    = RES_LAMP_OFF;
				cmd.emit       = st.hit_down;
				cmd.clear_lamp = st.hit_down;
				cmd.stand      = 1'b1;
				nxt            = ST_M_SWEEP;
			end
			default: nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= nxt;
	end

	assign busy = (state_q != ST_IDLE);

	`EGD_ASSERT_NEXT(a_last_ends_item, cmd.emit && cmd.last, state_q == ST_IDLE, "item went on after its final result")
	`EGD_ASSERT_SAME(a_cmd_after_sweep, state_q == ST_M_CMD, $past(state_q) == ST_M_SWEEP, "car command without a full sweep")
	`EGD_ASSERT_SAME(a_idle_quiet, state_q == ST_IDLE, !cmd.emit && !cmd.sweep_step && !cmd.manage, "activity while idle")
	`EGD_ASSERT_NEXT(a_weigh_after_sweep, (state_q == ST_W_SWEEP) && st.sweep_last, state_q == ST_W_EVAL, "weight skipped after sweep")

endmodule

FILE: src/elevator_group_dispatcher_unit.sv
// Top level of the elevator group dispatcher: controller plus datapath
`timescale 1ns / 1ps
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------------------
//  item in   | start, busy                 | operation, floor, call_direction, car
//  result    | result_strobe (1 cycle)     | kind, car_index, floor_number,
//            |                             | heading, lamp_group, last
//  config    | cfg_valid, cfg_ready        | cfg_index, cfg_data
//
//  An item is taken when start is high and busy is low. Each car looked at costs one
//  floor sweep: a placed hall call keeps busy high through check, two weighing sweeps
//  plus an eval step each, store, sweep of the chosen car, command and lamp; cabin calls
//  and ticks need one sweep, boarding a sweep after its three lamp-off slots.
//  Rejected, duplicate or stand-and-board hall items end in the check state.
//  Results leave one per cycle, registered in the cycle after their command; the receiver cannot stall.
//  arst_n resets all car state, call maps and config registers at once; no clearing pass.
//
module elevator_group_dispatcher_unit import egd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic [FLOOR_W-1:0]   floor,
	input  logic                 call_direction,
	input  logic                 car,
	// result channel
	output logic                 result_strobe,
	output logic [2:0]           kind,
	output logic                 car_index,
	output logic [FLOOR_W-1:0]   floor_number,
	output logic [1:0]           heading,
	output logic [1:0]           lamp_group,
	output logic                 last,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	egd_cmd_t  cmd;
	egd_stat_t st;
	logic      take;

	// config writes land at once, so the port never back-pressures
	assign cfg_ready = 1'b1;
	assign take      = start & ~busy;

	egd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	egd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.operation      (operation),
		.floor          (floor),
		.call_direction (call_direction),
		.car            (car),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.st             (st),
		.result_strobe  (result_strobe),
		.kind           (kind),
		.car_index      (car_index),
		.floor_number   (floor_number),
		.heading        (heading),
		.lamp_group     (lamp_group),
		.last           (last)
	);

endmodule
